// ===== rtl/fcr_pkg.sv =====
// Shared widths, constants and payload types for the conductor reflectance pipeline.
`timescale 1ns / 1ps
package fcr_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int IN_DATA_W = 48;

    localparam logic [15:0] ONE_Q15 = 16'd32768;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam int T1_W   = 25;
    localparam int NK_W   = 25;
    localparam int V1_W   = 51;
    localparam int W_W    = 26;
    localparam int SUM_W  = 27;
    localparam int V2_W   = 42;
    localparam int A_W    = 21;
    localparam int AC_W   = 37;
    localparam int DEN_W  = 42;
    localparam int NUM_W  = 58;
    localparam int Q_W    = 16;
    localparam int CW_W   = 40;
    localparam int S4_W   = 31;
    localparam int CRP_W  = 53;
    localparam int CR_W   = 38;

    typedef struct packed {
        logic [T1_W-1:0] t1mag;
        logic            t1neg;
        logic [15:0]     c;
        logic [30:0]     c2;
        logic [30:0]     s2;
    } sq1_side_t;

    typedef struct packed {
        logic [W_W-1:0] w;
        logic [15:0]    c;
        logic [30:0]    c2;
        logic [30:0]    s2;
    } sq2_side_t;

    typedef struct packed {
        logic [CW_W-1:0]  cw;
        logic [S4_W-1:0]  s4;
        logic [CRP_W-1:0] crossp;
    } dv1_side_t;

    typedef struct packed {
        logic [15:0] rs;
        logic        pzero;
    } dv2_side_t;

endpackage

// ===== rtl/conductor_fresnel_reflectance.sv =====
// Top level: unpolarized conductor Fresnel reflectance pipeline.
//
// One sample enters on the slave stream: n and k in Q4.12 and the incident
// cosine in Q1.15 (values above 1.0 are clamped). One reflectance in Q1.15,
// saturated to 0..1, leaves on the master stream for every accepted sample,
// in order.
// From input transaction to output valid the pipeline runs through four front
// stages, a 26-stage square root for a^2+b^2, a sum stage, a 21-stage square
// root for a, three product stages, a 16-stage divider for Rs, two stages for
// the p ratio operands, a 16-stage divider for Rp and the output register.
// Throughput is one transaction per cycle while the output is not stalled;
// the two square roots and two dividers each resolve one bit per stage.
// The whole pipeline advances when the output register is empty or taken;
// while a result waits and the receiver holds m_axis_tready low every stage
// holds and s_axis_tready is low. Reset clears all valid bits; the pipeline
// carries no other state.
`timescale 1ns / 1ps
module conductor_fresnel_reflectance (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [15:0] refr_index, [31:16] extinction, [47:32] cos_incident
    input  logic [fcr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [15:0] reflectance
    output logic [fcr_pkg::OUT_W-1:0]    m_axis_tdata
);

    import fcr_pkg::*;

    logic en;

    logic [15:0] n_in, k_in, c_in, cc_in;

    logic        s1_vld_reg;
    logic [15:0] s1_c_reg;
    logic [30:0] s1_c2_reg;
    logic [31:0] s1_nn_reg, s1_kk_reg, s1_nk_reg;

    logic            s2_vld_reg;
    logic [T1_W-1:0] s2_t1mag_reg;
    logic            s2_t1neg_reg;
    logic [NK_W-1:0] s2_nk2_reg;
    logic [15:0]     s2_c_reg;
    logic [30:0]     s2_c2_reg, s2_s2_reg;
    logic [30:0]     s2_s2_next;
    logic [32:0]     s2_neg_next;

    logic        s3_vld_reg;
    logic [49:0] s3_sq1_reg, s3_sq2_reg;
    sq1_side_t   s3_side_reg;

    logic            s4_vld_reg;
    logic [V1_W-1:0] s4_v_reg;
    sq1_side_t       s4_side_reg;

    logic           q1_vld;
    logic [W_W-1:0] q1_root;
    sq1_side_t      q1_side;

    logic             s5_vld_reg;
    logic [V2_W-1:0]  s5_v_reg;
    sq2_side_t        s5_side_reg;
    logic [SUM_W-1:0] s5_sum_next;

    logic           q2_vld;
    logic [A_W-1:0] q2_root;
    sq2_side_t      q2_side;

    logic            s6_vld_reg;
    logic [AC_W-1:0] s6_ac_reg;
    sq2_side_t       s6_side_reg;

    logic             s7_vld_reg;
    logic [DEN_W-1:0] s7_rnum_reg, s7_rden_reg;
    logic [56:0]      s7_cwp_reg;
    logic [61:0]      s7_s4p_reg;
    logic [21:0]      s7_ac15_reg;
    logic [30:0]      s7_s2_reg;
    logic [DEN_W-1:0] s7_wc_next;

    logic             s8_vld_reg;
    logic [NUM_W-1:0] s8_num_reg;
    logic [DEN_W-1:0] s8_den_reg;
    dv1_side_t        s8_side_reg;

    logic           d1_vld;
    logic [Q_W-1:0] d1_quo;
    dv1_side_t      d1_side;

    logic             s9_vld_reg;
    logic [15:0]      s9_rs_reg;
    logic [DEN_W-1:0] s9_pnum_reg, s9_pden_reg;
    logic [CR_W-1:0]  s9_cross_next;
    logic [DEN_W-1:0] s9_base_next, s9_pden_next;

    logic             s10_vld_reg;
    logic [NUM_W-1:0] s10_num_reg;
    logic [DEN_W-1:0] s10_den_reg;
    dv2_side_t        s10_side_reg;

    logic           d2_vld;
    logic [Q_W-1:0] d2_quo;
    dv2_side_t      d2_side;

    logic        out_vld_reg;
    logic [15:0] out_r_reg;
    logic [15:0] rp_next;
    logic [16:0] r_next;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_r_reg;

    assign n_in  = s_axis_tdata[15:0];
    assign k_in  = s_axis_tdata[31:16];
    assign c_in  = s_axis_tdata[47:32];
    assign cc_in = (c_in > ONE_Q15) ? ONE_Q15 : c_in;

    always_comb
    begin
        s2_s2_next  = ONE_Q30 - s1_c2_reg;
        s2_neg_next = 33'(s1_kk_reg) + 33'(s2_s2_next >> 6);
        s5_sum_next = q1_side.t1neg
                    ? ((27'(q1_root) >= 27'(q1_side.t1mag))
                        ? 27'(q1_root) - 27'(q1_side.t1mag) : '0)
                    : 27'(q1_root) + 27'(q1_side.t1mag);
        s7_wc_next  = (42'(s6_side_reg.w) << 14) + 42'(s6_side_reg.c2);
        s9_cross_next = d1_side.crossp[52:15];
        s9_base_next  = 42'(d1_side.cw) + 42'(d1_side.s4);
        s9_pden_next  = s9_base_next + 42'(s9_cross_next);
        rp_next = d2_side.pzero ? d2_side.rs
                : ((d2_quo > ONE_Q15) ? ONE_Q15 : d2_quo);
        r_next  = (17'(d2_side.rs) + 17'(rp_next) + 17'd1) >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= s_axis_tvalid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= q1_vld;
            s6_vld_reg  <= q2_vld;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= d1_vld;
            s10_vld_reg <= s9_vld_reg;
            out_vld_reg <= d2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_c_reg  <= cc_in;
            s1_c2_reg <= 31'(32'(cc_in) * 32'(cc_in));
            s1_nn_reg <= 32'(n_in) * 32'(n_in);
            s1_kk_reg <= 32'(k_in) * 32'(k_in);
            s1_nk_reg <= 32'(n_in) * 32'(k_in);

            if (33'(s1_nn_reg) >= s2_neg_next)
            begin
                s2_t1mag_reg <= T1_W'((33'(s1_nn_reg) - s2_neg_next) >> 8);
                s2_t1neg_reg <= 1'b0;
            end
            else
            begin
                s2_t1mag_reg <= T1_W'((s2_neg_next - 33'(s1_nn_reg)) >> 8);
                s2_t1neg_reg <= 1'b1;
            end
            s2_nk2_reg <= NK_W'(s1_nk_reg >> 7);
            s2_c_reg   <= s1_c_reg;
            s2_c2_reg  <= s1_c2_reg;
            s2_s2_reg  <= s2_s2_next;

            s3_sq1_reg        <= 50'(s2_t1mag_reg) * 50'(s2_t1mag_reg);
            s3_sq2_reg        <= 50'(s2_nk2_reg) * 50'(s2_nk2_reg);
            s3_side_reg.t1mag <= s2_t1mag_reg;
            s3_side_reg.t1neg <= s2_t1neg_reg;
            s3_side_reg.c     <= s2_c_reg;
            s3_side_reg.c2    <= s2_c2_reg;
            s3_side_reg.s2    <= s2_s2_reg;

            s4_v_reg    <= V1_W'(s3_sq1_reg) + V1_W'(s3_sq2_reg);
            s4_side_reg <= s3_side_reg;

            s5_v_reg       <= {s5_sum_next, 15'd0};
            s5_side_reg.w  <= q1_root;
            s5_side_reg.c  <= q1_side.c;
            s5_side_reg.c2 <= q1_side.c2;
            s5_side_reg.s2 <= q1_side.s2;

            s6_ac_reg   <= AC_W'(q2_root) * AC_W'(q2_side.c);
            s6_side_reg <= q2_side;

            s7_rden_reg <= s7_wc_next + 42'(s6_ac_reg);
            s7_rnum_reg <= (s7_wc_next >= 42'(s6_ac_reg)) ? s7_wc_next - 42'(s6_ac_reg) : '0;
            s7_cwp_reg  <= 57'(s6_side_reg.c2) * 57'(s6_side_reg.w);
            s7_s4p_reg  <= 62'(s6_side_reg.s2) * 62'(s6_side_reg.s2);
            s7_ac15_reg <= s6_ac_reg[36:15];
            s7_s2_reg   <= s6_side_reg.s2;

            s8_num_reg         <= {1'b0, s7_rnum_reg, 15'd0} + NUM_W'(s7_rden_reg >> 1);
            s8_den_reg         <= s7_rden_reg;
            s8_side_reg.cw     <= s7_cwp_reg[55:16];
            s8_side_reg.s4     <= s7_s4p_reg[60:30];
            s8_side_reg.crossp <= CRP_W'(s7_ac15_reg) * CRP_W'(s7_s2_reg);

            s9_rs_reg   <= (d1_quo > ONE_Q15) ? ONE_Q15 : d1_quo;
            s9_pden_reg <= s9_pden_next;
            s9_pnum_reg <= (s9_base_next >= 42'(s9_cross_next))
                         ? s9_base_next - 42'(s9_cross_next) : '0;

            s10_num_reg        <= NUM_W'(s9_rs_reg) * NUM_W'(s9_pnum_reg)
                                + NUM_W'(s9_pden_reg >> 1);
            s10_den_reg        <= s9_pden_reg;
            s10_side_reg.rs    <= s9_rs_reg;
            s10_side_reg.pzero <= (s9_pden_reg == '0);

            out_r_reg <= (r_next > 17'(ONE_Q15)) ? ONE_Q15 : r_next[15:0];
        end
    end

    fcr_isqrt #(
        .VW (V1_W),
        .SW ($bits(sq1_side_t))
    ) u_sqrt_w (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (s4_vld_reg),
        .val_in   (s4_v_reg),
        .side_in  (s4_side_reg),
        .vld_out  (q1_vld),
        .root_out (q1_root),
        .side_out (q1_side)
    );

    fcr_isqrt #(
        .VW (V2_W),
        .SW ($bits(sq2_side_t))
    ) u_sqrt_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (s5_vld_reg),
        .val_in   (s5_v_reg),
        .side_in  (s5_side_reg),
        .vld_out  (q2_vld),
        .root_out (q2_root),
        .side_out (q2_side)
    );

    fcr_div #(
        .NW (NUM_W),
        .DW (DEN_W),
        .QW (Q_W),
        .SW ($bits(dv1_side_t))
    ) u_div_rs (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (s8_vld_reg),
        .num_in   (s8_num_reg),
        .den_in   (s8_den_reg),
        .side_in  (s8_side_reg),
        .vld_out  (d1_vld),
        .quo_out  (d1_quo),
        .side_out (d1_side)
    );

    fcr_div #(
        .NW (NUM_W),
        .DW (DEN_W),
        .QW (Q_W),
        .SW ($bits(dv2_side_t))
    ) u_div_rp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (s10_vld_reg),
        .num_in   (s10_num_reg),
        .den_in   (s10_den_reg),
        .side_in  (s10_side_reg),
        .vld_out  (d2_vld),
        .quo_out  (d2_quo),
        .side_out (d2_side)
    );

`ifndef NO_ASSERTIONS
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= ONE_Q15))
        else $error("reflectance above one");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!en) |=> ($stable(s10_num_reg) && $stable(s10_vld_reg) && $stable(s5_v_reg)))
        else $error("pipeline moved while stalled");

    a_rp_le_rs: assert property (@(posedge clk) disable iff (!rst_n)
        (d2_vld && !d2_side.pzero) |-> (d2_quo <= d2_side.rs))
        else $error("p term exceeds s term");
`endif

endmodule

// ===== rtl/fcr_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband payload.
`timescale 1ns / 1ps
module fcr_isqrt #(
    parameter int VW = 51,
    parameter int SW = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vld_in,
    input  logic [VW-1:0]         val_in,
    input  logic [SW-1:0]         side_in,
    output logic                  vld_out,
    output logic [(VW+1)/2-1:0]   root_out,
    output logic [SW-1:0]         side_out
);

    localparam int RW = (VW + 1) / 2;
    localparam int TW = 2 * RW + 1;

    logic [VW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [SW-1:0] side_reg [RW];
    logic [RW-1:0] vld_reg;

    for (genvar g = 0; g < RW; g++) begin : g_stage
        localparam int J = RW - 1 - g;
        logic [VW-1:0] rem_i;
        logic [RW-1:0] root_i;
        logic [SW-1:0] side_i;
        logic          vld_i;
        logic [TW-1:0] trial;
        logic          ge;
        logic [VW-1:0] rem_next;
        logic [RW-1:0] root_next;

        if (g == 0) begin : g_first
            assign rem_i  = val_in;
            assign root_i = '0;
            assign side_i = side_in;
            assign vld_i  = vld_in;
        end
        else begin : g_rest
            assign rem_i  = rem_reg[g-1];
            assign root_i = root_reg[g-1];
            assign side_i = side_reg[g-1];
            assign vld_i  = vld_reg[g-1];
        end

        always_comb
        begin
            trial     = (TW'(root_i) << (J + 1)) | (TW'(1) << (2 * J));
            ge        = TW'(rem_i) >= trial;
            rem_next  = ge ? VW'(TW'(rem_i) - trial) : rem_i;
            root_next = ge ? (root_i | (RW'(1) << J)) : root_i;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
                side_reg[g] <= side_i;
            end
        end
    end

    assign vld_out  = vld_reg[RW-1];
    assign root_out = root_reg[RW-1];
    assign side_out = side_reg[RW-1];

endmodule

// ===== rtl/fcr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
`timescale 1ns / 1ps
module fcr_div #(
    parameter int NW = 58,
    parameter int DW = 42,
    parameter int QW = 16,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_in,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] den_in,
    input  logic [SW-1:0] side_in,
    output logic          vld_out,
    output logic [QW-1:0] quo_out,
    output logic [SW-1:0] side_out
);

    localparam int TW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [NW-1:0] rem_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic [QW-1:0] vld_reg;

    for (genvar g = 0; g < QW; g++) begin : g_stage
        localparam int I = QW - 1 - g;
        logic [NW-1:0] rem_i;
        logic [DW-1:0] den_i;
        logic [QW-1:0] quo_i;
        logic [SW-1:0] side_i;
        logic          vld_i;
        logic [TW-1:0] trial;
        logic          ge;
        logic [NW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (g == 0) begin : g_first
            assign rem_i  = num_in;
            assign den_i  = den_in;
            assign quo_i  = '0;
            assign side_i = side_in;
            assign vld_i  = vld_in;
        end
        else begin : g_rest
            assign rem_i  = rem_reg[g-1];
            assign den_i  = den_reg[g-1];
            assign quo_i  = quo_reg[g-1];
            assign side_i = side_reg[g-1];
            assign vld_i  = vld_reg[g-1];
        end

        always_comb
        begin
            trial    = TW'(den_i) << I;
            ge       = TW'(rem_i) >= trial;
            rem_next = ge ? NW'(TW'(rem_i) - trial) : rem_i;
            quo_next = ge ? (quo_i | (QW'(1) << I)) : quo_i;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                den_reg[g]  <= den_i;
                quo_reg[g]  <= quo_next;
                side_reg[g] <= side_i;
            end
        end
    end

    assign vld_out  = vld_reg[QW-1];
    assign quo_out  = quo_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule
